[design/stre_pkg.sv]
// Shared types and constants for the segmented transfer receiver.
package stre_pkg;

    localparam int CHANNELS    = 2;
    localparam int MAX_PAYLOAD = 6;

    localparam int LEN_W   = 24;
    localparam int SUM_W   = 32;
    localparam int SEQ_W   = 8;
    localparam int CNT_W   = 3;
    localparam int DATA_W  = 48;
    localparam int BC_W    = 25;
    localparam int OFF_W   = 8;
    localparam int BSUM_W  = $clog2(MAX_PAYLOAD * 255 + 1);

    localparam logic [SUM_W-1:0] SUM_START = 32'h1000_0000;
    localparam logic [BC_W-1:0]  COUNT_MAX = 25'h1FF_FFFF;
    localparam logic [LEN_W-1:0] LEN_MAX   = 24'hFF_FFFF;

    localparam logic CMD_APPLY  = 1'b0;
    localparam logic CMD_DATA   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Both inner queues are two entries deep.
    localparam int          Q_DEPTH = 2;
    localparam int          QPTR_W  = 1;
    localparam logic [1:0]  Q_FULL  = 2'd2;

    // Classified request handed from front to back.
    typedef struct packed {
        logic              command;
        logic              channel;
        logic              bad_channel;
        logic [LEN_W-1:0]  announced_length;
        logic [SUM_W-1:0]  announced_sum;
        logic [SEQ_W-1:0]  sequence_req;
        logic [CNT_W-1:0]  count;
        logic [BSUM_W-1:0] byte_sum;
    } t_item;

    // One acknowledgement.
    typedef struct packed {
        logic              ack_channel;
        logic              status;
        logic              complete;
        logic [OFF_W-1:0]  write_offset;
        logic [CNT_W-1:0]  write_count;
        logic [LEN_W-1:0]  total_length;
    } t_ack;

endpackage

[design/stre_front.sv]
// Front end: accepts requests, clamps and sums payload bytes, queues them.
module stre_front
    import stre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_command,
    input  logic              i_channel,
    input  logic [LEN_W-1:0]  i_announced_length,
    input  logic [SUM_W-1:0]  i_announced_sum,
    input  logic [SEQ_W-1:0]  i_sequence_req,
    input  logic [CNT_W-1:0]  i_payload_count,
    input  logic [DATA_W-1:0] i_payload,
    output logic              o_valid,
    output t_item             o_item,
    input  logic              i_take
);

    t_item             r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_cnt, n_cnt;
    t_item             w_item;
    logic              w_push_fire;
    logic              w_pop_fire;

    // Classify the request: clamp the byte count and sum the live bytes.
    always_comb begin
        logic [CNT_W-1:0]  cnt;
        logic [BSUM_W-1:0] bsum;
        cnt  = (i_payload_count > CNT_W'(MAX_PAYLOAD)) ? CNT_W'(MAX_PAYLOAD)
                                                      : i_payload_count;
        bsum = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (CNT_W'(i) < cnt) begin
                bsum = bsum + BSUM_W'(i_payload[8*i +: 8]);
            end
        end
        w_item.command          = i_command;
        w_item.channel          = i_channel;
        w_item.bad_channel      = (32'(i_channel) >= CHANNELS);
        w_item.announced_length = i_announced_length;
        w_item.announced_sum    = i_announced_sum;
        w_item.sequence_req     = i_sequence_req;
        w_item.count            = cnt;
        w_item.byte_sum         = bsum;
    end

    assign o_full      = (r_cnt == Q_FULL);
    assign o_valid     = (r_cnt != 2'd0);
    assign o_item      = r_q[r_rd_ptr];
    assign w_push_fire = i_push && !o_full;
    assign w_pop_fire  = i_take && o_valid;

    // Advance queue pointers and fill level.
    always_comb begin
        n_wr_ptr = w_push_fire ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop_fire ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_push_fire} - {1'b0, w_pop_fire};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the classified request.
    always_ff @(posedge i_clk) begin
        if (w_push_fire) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

[design/stre_back.sv]
// Back end: per-channel transfer state, checksum check and result queue.
module stre_back
    import stre_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_empty,
    output t_ack  o_ack,
    input  logic  i_pop
);

    logic [LEN_W-1:0]  r_exp_len   [CHANNELS];
    logic [SUM_W-1:0]  r_exp_sum   [CHANNELS];
    logic [SUM_W-1:0]  r_run_sum   [CHANNELS];
    logic [SEQ_W-1:0]  r_frame_cnt [CHANNELS];
    logic [BC_W-1:0]   r_byte_cnt  [CHANNELS];

    t_ack              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_cnt, n_cnt;

    logic              w_take_fire;
    logic              w_pop_fire;
    t_ack              w_ack;
    logic [SUM_W-1:0]  w_new_sum;
    logic [BC_W-1:0]   w_new_bc;
    logic              w_upd_data;
    logic              w_adv_frame;
    logic              w_apply;

    assign o_take      = (r_cnt != Q_FULL);
    assign w_take_fire = i_valid && o_take;
    assign w_pop_fire  = i_pop && !o_empty;
    assign o_empty     = (r_cnt == 2'd0);
    assign o_ack       = r_q[r_rd_ptr];

    // Evaluate the request against its channel's state.
    always_comb begin
        logic [BC_W:0]    sum_bc;
        logic             seq_ok;
        logic             reached;
        logic [OFF_W-1:0] offset;
        sum_bc      = {1'b0, r_byte_cnt[i_item.channel]} + (BC_W+1)'(i_item.count);
        w_new_bc    = sum_bc[BC_W] ? COUNT_MAX : sum_bc[BC_W-1:0];
        w_new_sum   = r_run_sum[i_item.channel] - SUM_W'(i_item.byte_sum);
        seq_ok      = (i_item.sequence_req == r_frame_cnt[i_item.channel]);
        reached     = (w_new_bc >= {1'b0, r_exp_len[i_item.channel]});
        offset      = (i_item.count != '0) ? r_byte_cnt[i_item.channel][OFF_W-1:0]
                                           : '0;
        w_apply     = !i_item.bad_channel && (i_item.command == CMD_APPLY);
        w_upd_data  = !i_item.bad_channel && (i_item.command == CMD_DATA) && seq_ok;
        w_adv_frame = w_upd_data && !reached;

        w_ack              = '0;
        w_ack.ack_channel  = i_item.channel;
        w_ack.status       = STATUS_ERR;
        if (w_apply) begin
            w_ack.status = STATUS_OK;
        end else if (w_upd_data) begin
            w_ack.write_offset = offset;
            w_ack.write_count  = i_item.count;
            if (!reached) begin
                w_ack.status = STATUS_OK;
            end else if (w_new_sum == r_exp_sum[i_item.channel]) begin
                w_ack.status       = STATUS_OK;
                w_ack.complete     = 1'b1;
                w_ack.total_length = w_new_bc[BC_W-1] ? LEN_MAX : w_new_bc[LEN_W-1:0];
            end
        end
    end

    // Update channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_exp_len[c]   <= '0;
                r_exp_sum[c]   <= '0;
                r_run_sum[c]   <= '0;
                r_frame_cnt[c] <= '0;
                r_byte_cnt[c]  <= '0;
            end
        end else if (w_take_fire) begin
            if (w_apply) begin
                r_exp_len[i_item.channel]   <= i_item.announced_length;
                r_exp_sum[i_item.channel]   <= i_item.announced_sum;
                r_run_sum[i_item.channel]   <= SUM_START;
                r_frame_cnt[i_item.channel] <= '0;
                r_byte_cnt[i_item.channel]  <= '0;
            end else if (w_upd_data) begin
                r_run_sum[i_item.channel]  <= w_new_sum;
                r_byte_cnt[i_item.channel] <= w_new_bc;
                if (w_adv_frame) begin
                    r_frame_cnt[i_item.channel] <= r_frame_cnt[i_item.channel] + SEQ_W'(1);
                end
            end
        end
    end

    // Advance result queue pointers and fill level.
    always_comb begin
        n_wr_ptr = w_take_fire ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop_fire ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, w_take_fire} - {1'b0, w_pop_fire};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Hold the acknowledgement until it is popped.
    always_ff @(posedge i_clk) begin
        if (w_take_fire) begin
            r_q[r_wr_ptr] <= w_ack;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_FULL)
        else $error("result queue overfilled");

    a_complete_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_fire && w_ack.complete |-> w_ack.status == STATUS_OK && w_upd_data)
        else $error("complete without an accepted data frame");

    a_apply_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_fire && w_apply |=> r_byte_cnt[$past(i_item.channel)] == '0
                                   && r_run_sum[$past(i_item.channel)] == SUM_START)
        else $error("announce did not restart the channel");

    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_fire && !w_upd_data |-> w_ack.write_count == '0
                                       && w_ack.total_length == '0)
        else $error("write reported for a rejected request");
`endif

endmodule

[design/segmented_transfer_receiver_core.sv]
// An accepted request is stored in the front queue; the back end then takes it and registers
// its acknowledgement in the result queue, from which it can be popped.
// Throughput: one request per cycle while no queue is full; a 2-entry queue sits in the
// front and in the result path. The per-channel state update in the back end sets the rate.
// Reset (synchronous, active low) clears both queues and all channel state to zero.
// Top level of the segmented transfer receiver.
module segmented_transfer_receiver_core
    import stre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_command,
    input  logic              i_channel,
    input  logic [LEN_W-1:0]  i_announced_length,
    input  logic [SUM_W-1:0]  i_announced_sum,
    input  logic [SEQ_W-1:0]  i_sequence_req,
    input  logic [CNT_W-1:0]  i_payload_count,
    input  logic [DATA_W-1:0] i_payload,
    output logic              empty,
    input  logic              pop,
    output logic              o_ack_channel,
    output logic              o_status,
    output logic              o_complete,
    output logic [OFF_W-1:0]  o_write_offset,
    output logic [CNT_W-1:0]  o_write_count,
    output logic [LEN_W-1:0]  o_total_length
);

    t_item w_item;
    logic  w_valid;
    logic  w_take;
    t_ack  w_ack;

    // Accept and classify requests.
    stre_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_command          (i_command),
        .i_channel          (i_channel),
        .i_announced_length (i_announced_length),
        .i_announced_sum    (i_announced_sum),
        .i_sequence_req     (i_sequence_req),
        .i_payload_count    (i_payload_count),
        .i_payload          (i_payload),
        .o_valid            (w_valid),
        .o_item             (w_item),
        .i_take             (w_take)
    );

    // Carry out requests and queue acknowledgements.
    stre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_empty (empty),
        .o_ack   (w_ack),
        .i_pop   (pop)
    );

    assign o_ack_channel  = w_ack.ack_channel;
    assign o_status       = w_ack.status;
    assign o_complete     = w_ack.complete;
    assign o_write_offset = w_ack.write_offset;
    assign o_write_count  = w_ack.write_count;
    assign o_total_length = w_ack.total_length;

endmodule

[dv/tb.sv]
// Self-checking testbench for the segmented transfer receiver core.
`timescale 1ns / 1ps

module tb;
    import stre_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int TAIL_ITEMS  = 200;
    localparam int DRAIN_EVERY = 450;
    localparam int WRAP_FRAMES = 258;

    // One request as seen on the input ports.
    typedef struct packed {
        logic              command;
        logic              channel;
        logic [LEN_W-1:0]  announced_length;
        logic [SUM_W-1:0]  announced_sum;
        logic [SEQ_W-1:0]  sequence_req;
        logic [CNT_W-1:0]  payload_count;
        logic [DATA_W-1:0] payload;
    } t_xfer_req;

    // Directed row: request plus an optional hand-written acknowledgement.
    typedef struct packed {
        t_xfer_req req;
        logic      typed;
        t_ack      ack;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    logic              i_command = 1'b0;
    logic              i_channel = 1'b0;
    logic [LEN_W-1:0]  i_announced_length = '0;
    logic [SUM_W-1:0]  i_announced_sum = '0;
    logic [SEQ_W-1:0]  i_sequence_req = '0;
    logic [CNT_W-1:0]  i_payload_count = '0;
    logic [DATA_W-1:0] i_payload = '0;
    logic              full;
    logic              empty;
    logic              o_ack_channel;
    logic              o_status;
    logic              o_complete;
    logic [OFF_W-1:0]  o_write_offset;
    logic [CNT_W-1:0]  o_write_count;
    logic [LEN_W-1:0]  o_total_length;

    segmented_transfer_receiver_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_command          (i_command),
        .i_channel          (i_channel),
        .i_announced_length (i_announced_length),
        .i_announced_sum    (i_announced_sum),
        .i_sequence_req     (i_sequence_req),
        .i_payload_count    (i_payload_count),
        .i_payload          (i_payload),
        .empty              (empty),
        .pop                (pop),
        .o_ack_channel      (o_ack_channel),
        .o_status           (o_status),
        .o_complete         (o_complete),
        .o_write_offset     (o_write_offset),
        .o_write_count      (o_write_count),
        .o_total_length     (o_total_length)
    );

    // Predicted per-channel transfer state.
    logic [LEN_W-1:0] want_len  [CHANNELS];
    logic [SUM_W-1:0] want_sum  [CHANNELS];
    logic [SUM_W-1:0] live_sum  [CHANNELS];
    logic [SEQ_W-1:0] next_seq  [CHANNELS];
    logic [BC_W-1:0]  rx_bytes  [CHANNELS];

    t_ack      pending_acks[$];
    t_stim_row directed_rows[$];
    logic [CNT_W-1:0]  frame_counts[$];
    logic [DATA_W-1:0] frame_bytes[$];

    int   items_sent = 0;
    int   mismatch_count = 0;
    bit   calm = 1'b0;
    bit   tail_phase = 1'b0;
    bit   wrap_done = 1'b0;
    int   pop_stall_left = 0;
    int   pop_calm_left = 0;
    t_ack oldest_ack;

    // Toggle the clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_xfer_req make_req(input logic cmd, input logic ch,
                                           input logic [LEN_W-1:0] len,
                                           input logic [SUM_W-1:0] sum,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [DATA_W-1:0] data);
        t_xfer_req r;
        r.command          = cmd;
        r.channel          = ch;
        r.announced_length = len;
        r.announced_sum    = sum;
        r.sequence_req     = seq;
        r.payload_count    = cnt;
        r.payload          = data;
        return r;
    endfunction

    function automatic t_ack ack_word(input logic ch, input logic st, input logic done,
                                      input logic [OFF_W-1:0] off,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic [LEN_W-1:0] total);
        t_ack a;
        a.ack_channel  = ch;
        a.status       = st;
        a.complete     = done;
        a.write_offset = off;
        a.write_count  = cnt;
        a.total_length = total;
        return a;
    endfunction

    function automatic t_xfer_req noise_req();
        return make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        LEN_W'($urandom()), $urandom(), SEQ_W'($urandom()),
                        CNT_W'($urandom_range(0, 7)), DATA_W'({$urandom(), $urandom()}));
    endfunction

    // Advance the predicted channel state by one request and build its ack.
    function automatic t_ack predict_ack(input t_xfer_req r);
        t_ack          a;
        int unsigned   ch;
        int unsigned   n;
        logic [BC_W:0] new_count;
        logic [OFF_W-1:0] off;
        a = '0;
        a.ack_channel = r.channel;
        ch = 32'(r.channel);
        if (ch >= CHANNELS) begin
            a.status = STATUS_ERR;
            return a;
        end
        if (r.command == CMD_APPLY) begin
            want_len[ch] = r.announced_length;
            want_sum[ch] = r.announced_sum;
            live_sum[ch] = SUM_START;
            next_seq[ch] = '0;
            rx_bytes[ch] = '0;
            a.status = STATUS_OK;
            return a;
        end
        if (r.sequence_req != next_seq[ch]) begin
            a.status = STATUS_ERR;
            return a;
        end
        n = (r.payload_count > MAX_PAYLOAD) ? MAX_PAYLOAD : 32'(r.payload_count);
        for (int i = 0; i < n; i++)
            live_sum[ch] = live_sum[ch] - SUM_W'(r.payload[8*i +: 8]);
        off = rx_bytes[ch][OFF_W-1:0];
        new_count = {1'b0, rx_bytes[ch]} + (BC_W+1)'(n);
        if (new_count > {1'b0, COUNT_MAX})
            new_count = {1'b0, COUNT_MAX};
        rx_bytes[ch] = new_count[BC_W-1:0];
        a.write_offset = (n != 0) ? off : '0;
        a.write_count  = CNT_W'(n);
        if (rx_bytes[ch] >= {1'b0, want_len[ch]}) begin
            if (live_sum[ch] == want_sum[ch]) begin
                a.status = STATUS_OK;
                a.complete = 1'b1;
                a.total_length = (rx_bytes[ch] > {1'b0, LEN_MAX}) ? LEN_MAX
                                                                  : rx_bytes[ch][LEN_W-1:0];
            end else begin
                a.status = STATUS_ERR;
            end
        end else begin
            next_seq[ch] = next_seq[ch] + SEQ_W'(1);
            a.status = STATUS_OK;
        end
        return a;
    endfunction

    // Present one request, hold it until accepted, then queue its expected ack.
    task automatic send_request(input t_xfer_req r, input logic typed, input t_ack typed_ack);
        t_ack predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_command          <= r.command;
        i_channel          <= r.channel;
        i_announced_length <= r.announced_length;
        i_announced_sum    <= r.announced_sum;
        i_sequence_req     <= r.sequence_req;
        i_payload_count    <= r.payload_count;
        i_payload          <= r.payload;
        push               <= 1'b1;
        do @(posedge i_clk); while (full);
        predicted = predict_ack(r);
        pending_acks.push_back(typed ? typed_ack : predicted);
        items_sent++;
    endtask

    // Hold off new requests until every expected ack has come back.
    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_acks.size() != 0);
    endtask

    // Run one transfer: announce, then in-order frames with some noise mixed in.
    task automatic run_transfer();
        logic              ch;
        logic [LEN_W-1:0]  len;
        logic [SUM_W-1:0]  byte_sum;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] data;
        int unsigned       total;
        int unsigned       eff;
        int                cap;
        bit                wrap;
        ch = 1'($urandom_range(0, 1));
        tail_phase = (items_sent + TAIL_ITEMS >= ITEM_TARGET);
        calm = tail_phase || ($urandom_range(0, 5) == 0);
        wrap = !wrap_done && items_sent >= 500;
        wrap_done = wrap_done || wrap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = LEN_W'($urandom_range(0, 30));
            6, 7:             len = LEN_W'($urandom_range(31, 400));
            8:                len = LEN_W'($urandom_range(0, 6));
            default:          len = LEN_W'($urandom());
        endcase
        // Walk the frame counter through its wrap with empty frames.
        if (wrap)
            len = LEN_W'(1);
        cap = wrap ? WRAP_FRAMES + 1 : 40;
        frame_counts.delete();
        frame_bytes.delete();
        total = 0;
        byte_sum = '0;
        while ((total < len || frame_counts.size() == 0) && frame_counts.size() < cap) begin
            if (wrap)
                cnt = (frame_counts.size() < WRAP_FRAMES) ? 3'd0 : 3'd1;
            else
                cnt = CNT_W'($urandom_range(0, 7));
            data = DATA_W'({$urandom(), $urandom()});
            eff = (cnt > MAX_PAYLOAD) ? MAX_PAYLOAD : 32'(cnt);
            for (int i = 0; i < eff; i++)
                byte_sum = byte_sum + SUM_W'(data[8*i +: 8]);
            total += eff;
            frame_counts.push_back(cnt);
            frame_bytes.push_back(data);
        end
        sum = ($urandom_range(0, 4) != 0) ? SUM_START - byte_sum : $urandom();
        send_request(make_req(CMD_APPLY, ch, len, sum, SEQ_W'($urandom()),
                              CNT_W'($urandom_range(0, 7)),
                              DATA_W'({$urandom(), $urandom()})), 1'b0, '0);
        foreach (frame_counts[idx]) begin
            if (!wrap && $urandom_range(0, 99) < 8)
                send_request(noise_req(), 1'b0, '0);
            if (!wrap && $urandom_range(0, 99) < 5)
                send_request(make_req(CMD_DATA, ch, LEN_W'($urandom()), $urandom(),
                                      SEQ_W'(idx + $urandom_range(1, 255)), frame_counts[idx],
                                      frame_bytes[idx]), 1'b0, '0);
            send_request(make_req(CMD_DATA, ch, LEN_W'($urandom()), $urandom(), SEQ_W'(idx),
                                  frame_counts[idx], frame_bytes[idx]), 1'b0, '0);
        end
        // Repeat the last frame now and then, after completion or not.
        if ($urandom_range(0, 3) == 0)
            send_request(make_req(CMD_DATA, ch, LEN_W'($urandom()), $urandom(),
                                  SEQ_W'(frame_counts.size() - 1),
                                  frame_counts[frame_counts.size() - 1],
                                  frame_bytes[frame_bytes.size() - 1]), 1'b0, '0);
    endtask

    // Check each popped ack against the oldest expectation, then drive pop.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_acks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected ack: ch=%0d st=%0d cmp=%0d off=%0d cnt=%0d tot=%0d",
                             o_ack_channel, o_status, o_complete, o_write_offset,
                             o_write_count, o_total_length);
            end else begin
                oldest_ack = pending_acks.pop_front();
                if (oldest_ack.ack_channel !== o_ack_channel
                        || oldest_ack.status !== o_status
                        || oldest_ack.complete !== o_complete
                        || oldest_ack.write_offset !== o_write_offset
                        || oldest_ack.write_count !== o_write_count
                        || oldest_ack.total_length !== o_total_length) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ack mismatch: exp ch=%0d st=%0d cmp=%0d off=%0d cnt=%0d ",
                                  "tot=%0d / got ch=%0d st=%0d cmp=%0d off=%0d cnt=%0d tot=%0d"},
                                 oldest_ack.ack_channel, oldest_ack.status,
                                 oldest_ack.complete, oldest_ack.write_offset,
                                 oldest_ack.write_count, oldest_ack.total_length,
                                 o_ack_channel, o_status, o_complete, o_write_offset,
                                 o_write_count, o_total_length);
                end
            end
        end
        if (tail_phase || pop_calm_left > 0) begin
            pop <= 1'b1;
            if (pop_calm_left > 0)
                pop_calm_left--;
        end else if (pop_stall_left > 0) begin
            pop <= 1'b0;
            pop_stall_left--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    pop <= 1'b0;
                    pop_stall_left = $urandom_range(0, 3);
                end
                2: begin
                    pop <= 1'b1;
                    pop_calm_left = $urandom_range(20, 60);
                end
                default: pop <= 1'b1;
            endcase
        end
    end

    // Stimulus: reset, directed table, random transfers, drain and verdict.
    initial begin
        int next_drain;
        for (int c = 0; c < CHANNELS; c++) begin
            want_len[c] = '0;
            want_sum[c] = '0;
            live_sum[c] = '0;
            next_seq[c] = '0;
            rx_bytes[c] = '0;
        end

        // Data before any announce runs on the reset state.
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b0, STATUS_OK, 1'b1, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'd5, 3'd2, '1),
                                 1'b1, ack_word(1'b1, STATUS_ERR, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'd0, 3'd3,
                                          48'h0000_0011_2233), 1'b0, t_ack'('0)});
        // Largest length and sum; never completes.
        directed_rows.push_back({make_req(CMD_APPLY, 1'b0, LEN_MAX, 32'hFFFF_FFFF, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b0, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd0, 3'd6, '1),
                                 1'b0, t_ack'('0)});
        // Oversized payload count is clipped to six bytes.
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd1, 3'd7,
                                          48'h8040_2010_0804), 1'b0, t_ack'('0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd0, 3'd6, '1),
                                 1'b1, ack_word(1'b0, STATUS_ERR, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_APPLY, 1'b1, 24'd0, SUM_START, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b1, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'd0, 3'd0, '1),
                                 1'b1, ack_word(1'b1, STATUS_OK, 1'b1, 8'd0, 3'd0, 24'd0)});
        // Data after completion is evaluated again.
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'd0, 3'd0, '1),
                                 1'b0, t_ack'('0)});
        directed_rows.push_back({make_req(CMD_APPLY, 1'b0, 24'd12, 32'h0FFF_FFEE, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b0, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd0, 3'd6,
                                          48'h0101_0101_0101), 1'b0, t_ack'('0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd1, 3'd6,
                                          48'h0202_0202_0202),
                                 1'b1, ack_word(1'b0, STATUS_OK, 1'b1, 8'd6, 3'd6, 24'd12)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd1, 3'd6,
                                          48'h0202_0202_0202), 1'b0, t_ack'('0)});
        directed_rows.push_back({make_req(CMD_APPLY, 1'b1, 24'd0, 32'd0, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b1, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'hFF, 3'd1, '0),
                                 1'b1, ack_word(1'b1, STATUS_ERR, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_APPLY, 1'b0, 24'd1, 32'hFFFF_FFFF, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b0, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b0, '0, '0, 8'd0, 3'd1, '1),
                                 1'b0, t_ack'('0)});
        directed_rows.push_back({make_req(CMD_APPLY, 1'b1, 24'd3, SUM_START, 8'd0, 3'd0, '0),
                                 1'b1, ack_word(1'b1, STATUS_OK, 1'b0, 8'd0, 3'd0, 24'd0)});
        directed_rows.push_back({make_req(CMD_DATA, 1'b1, '0, '0, 8'd0, 3'd3,
                                          48'hFFFF_FF00_0000),
                                 1'b1, ack_word(1'b1, STATUS_OK, 1'b1, 8'd0, 3'd3, 24'd3)});

        // Hold reset before releasing it.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].ack);
        hold_until_drained();

        next_drain = items_sent + DRAIN_EVERY;
        while (items_sent < ITEM_TARGET) begin
            run_transfer();
            if (items_sent >= next_drain) begin
                hold_until_drained();
                next_drain = items_sent + DRAIN_EVERY;
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[segmented_transfer_receiver_core] OK");
        else
            $display("[segmented_transfer_receiver_core] ERROR");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #4_000_000;
        $display("[segmented_transfer_receiver_core] ERROR");
        $finish;
    end

endmodule
